// ===== hw/rtl/cigar_run_counter_macros.svh =====
// ---------------------------------------------------------------------------
// CIGAR run counter assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the synchronous active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef CIGAR_RUN_COUNTER_MACROS_SVH
`define CIGAR_RUN_COUNTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CIG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cigar_run_counter: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cigar_run_counter: next-cycle check failed");

`endif

// ===== hw/rtl/cigar_pkg.sv =====
// ---------------------------------------------------------------------------
// CIGAR run counter package
// Character codes, counter slots, widths and the control bundle that the
// run parser hands to the counter bank.
// ---------------------------------------------------------------------------
package cigar_pkg;

    localparam int CHAR_W  = 8;
    localparam int THR_W   = 16;
    localparam int RUN_W   = 16;
    localparam int OUT_W   = 32;
    localparam int NUM_CNT = 9;
    // Run length times ten plus one digit fits in this many bits.
    localparam int NEXT_W  = RUN_W + 4;

    localparam logic [THR_W-1:0] DEFAULT_THRESHOLD = 16'd50;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DEL  = 8'h44;
    localparam logic [CHAR_W-1:0] CH_INS  = 8'h49;
    localparam logic [CHAR_W-1:0] CH_MIS  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_MAT  = 8'h3D;

    // Counter slots; each region's large counter sits one above it.
    localparam int IDX_DEL     = 0;
    localparam int IDX_INS     = 2;
    localparam int IDX_MIS     = 4;
    localparam int IDX_MAT     = 6;
    localparam int IDX_PERFECT = 8;

    // Runs closed in the current string, saturating at two.
    localparam logic [1:0] RUNS_NONE = 2'd0;
    localparam logic [1:0] RUNS_ONE  = 2'd1;
    localparam logic [1:0] RUNS_MANY = 2'd2;

    // Update request from the parser to the counter bank.
    typedef struct packed {
        logic               en;
        logic [NUM_CNT-1:0] bump;
    } t_cnt_ctl;

endpackage

// ===== hw/rtl/cigar_count_bank.sv =====
// ---------------------------------------------------------------------------
// CIGAR counter bank
// Nine saturating event counters, cleared only by reset, with their next
// values presented clamped or extended to the 32-bit result width.
// ---------------------------------------------------------------------------
module cigar_count_bank
    import cigar_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cnt_ctl                 i_ctl,
    output logic [NUM_CNT*OUT_W-1:0] o_next_sat
);

    logic [COUNT_WIDTH-1:0] r_cnt [NUM_CNT];
    logic [COUNT_WIDTH-1:0] n_cnt [NUM_CNT];

    // Saturating increment for each requested slot.
    always_comb begin
        for (int k = 0; k < NUM_CNT; k++) begin
            n_cnt[k] = r_cnt[k];
            if (i_ctl.en && i_ctl.bump[k] && !(&r_cnt[k])) begin
                n_cnt[k] = r_cnt[k] + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            for (int k = 0; k < NUM_CNT; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    // Clamp or extend each next value to the result width.
    for (genvar g = 0; g < NUM_CNT; g++) begin : g_out
        if (COUNT_WIDTH > OUT_W) begin : g_clamp
            assign o_next_sat[g*OUT_W +: OUT_W] =
                (|n_cnt[g][COUNT_WIDTH-1:OUT_W]) ? {OUT_W{1'b1}} : n_cnt[g][OUT_W-1:0];
        end else begin : g_extend
            assign o_next_sat[g*OUT_W +: OUT_W] = OUT_W'(n_cnt[g]);
        end
    end

endmodule

// ===== hw/rtl/cigar_run_counter.sv =====
// ---------------------------------------------------------------------------
// CIGAR run counter
// Parses difference-CIGAR strings one byte per transfer and keeps saturating
// counts of D, I, X and = runs, their large runs, and perfect alignments.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                  Transfer
//  s_axis    in         tdata[7:0] character                     one per byte
//  m_axis    out        tdata[287:0] nine 32-bit counters        one per NUL
//  cfg       in         i_cfg_wdata large_run_threshold          when i_cfg_we
//
//  A byte is registered on transfer and parsed from the input register; a
//  result is registered when its terminating NUL byte is parsed. One byte per
//  cycle is sustained unless a NUL byte waits in the input register, which
//  it does only while the result register still holds an untaken result.
//  Reset clears the threshold to 50, the parse state and all counters.
//
module cigar_run_counter
    import cigar_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // [7:0] character
    // Result stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [31:0] deletions, [63:32] large_deletions, [95:64] insertions,
    // [127:96] large_insertions, [159:128] mismatches, [191:160] large_mismatches,
    // [223:192] matches_res, [255:224] large_matches, [287:256] perfect_alignments
    output logic [NUM_CNT*OUT_W-1:0] m_axis_tdata,
    // Configuration
    input  logic                     i_cfg_we,
    input  logic [THR_W-1:0]         i_cfg_wdata     // large_run_threshold
);

`include "cigar_run_counter_macros.svh"

    logic                     r_in_valid;
    logic [CHAR_W-1:0]        r_char;
    logic [THR_W-1:0]         r_thr;
    logic [RUN_W-1:0]         r_run;
    logic [RUN_W-1:0]         n_run;
    logic [1:0]               r_runs;
    logic [1:0]               n_runs;
    logic                     r_last_match;
    logic                     n_last_match;
    logic                     r_out_valid;
    logic [NUM_CNT*OUT_W-1:0] r_out_data;

    logic                     is_term;
    logic                     is_digit;
    logic                     run_large;
    logic                     out_free;
    logic                     proc_fire;
    logic [3:0]               digit_diff;
    logic [NEXT_W-1:0]        next_run;
    logic [NUM_CNT*OUT_W-1:0] next_sat;
    t_cnt_ctl                 cnt_ctl;

    // Byte classification and handshake control.
    assign is_term    = (r_char == CH_NUL);
    assign is_digit   = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign out_free   = !r_out_valid || m_axis_tready;
    assign proc_fire  = r_in_valid && (!is_term || out_free);
    assign s_axis_tready = !r_in_valid || proc_fire;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Run length accumulation: times ten by shift-and-add, then clamp.
    assign digit_diff = 4'(r_char - CH_ZERO);
    assign next_run   = (NEXT_W'(r_run) << 3) + (NEXT_W'(r_run) << 1)
                      + NEXT_W'(digit_diff);
    assign run_large  = (r_run >= r_thr);

    // Parse state update and counter requests.
    always_comb begin
        n_run        = r_run;
        n_runs       = r_runs;
        n_last_match = r_last_match;
        cnt_ctl.en   = proc_fire;
        cnt_ctl.bump = '0;
        if (is_term) begin
            cnt_ctl.bump[IDX_PERFECT] = (r_runs == RUNS_ONE) && r_last_match;
            n_run        = '0;
            n_runs       = RUNS_NONE;
            n_last_match = 1'b0;
        end else if (is_digit) begin
            n_run = (next_run >= NEXT_W'(r_thr)) ? r_thr : next_run[RUN_W-1:0];
        end else begin
            case (r_char)
                CH_DEL: begin
                    cnt_ctl.bump[IDX_DEL]     = 1'b1;
                    cnt_ctl.bump[IDX_DEL + 1] = run_large;
                end
                CH_INS: begin
                    cnt_ctl.bump[IDX_INS]     = 1'b1;
                    cnt_ctl.bump[IDX_INS + 1] = run_large;
                end
                CH_MIS: begin
                    cnt_ctl.bump[IDX_MIS]     = 1'b1;
                    cnt_ctl.bump[IDX_MIS + 1] = run_large;
                end
                CH_MAT: begin
                    cnt_ctl.bump[IDX_MAT]     = 1'b1;
                    cnt_ctl.bump[IDX_MAT + 1] = run_large;
                end
                default: begin
                    cnt_ctl.bump = '0;
                end
            endcase
            n_runs       = (r_runs == RUNS_MANY) ? RUNS_MANY : r_runs + 2'd1;
            n_last_match = (r_char == CH_MAT);
            n_run        = '0;
        end
    end

    cigar_count_bank #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cnt_ctl),
        .o_next_sat (next_sat)
    );

    // Control registers: input stage, parse state, threshold, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_thr        <= DEFAULT_THRESHOLD;
            r_run        <= '0;
            r_runs       <= RUNS_NONE;
            r_last_match <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (proc_fire) begin
                r_run        <= n_run;
                r_runs       <= n_runs;
                r_last_match <= n_last_match;
            end
            if (proc_fire && is_term) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_char <= s_axis_tdata;
        end
        if (proc_fire && is_term) begin
            r_out_data <= next_sat;
        end
    end

    // Checks on parse and result control.
    `CIG_ASSERT_NEXT(a_term_clears_state, i_clk, i_rst_n, proc_fire && is_term,
        (r_run == '0) && (r_runs == RUNS_NONE) && !r_last_match)
    `CIG_ASSERT_NEXT(a_term_gives_result, i_clk, i_rst_n, proc_fire && is_term,
        r_out_valid)
    `CIG_ASSERT_SAME(a_perfect_only_at_term, i_clk, i_rst_n, cnt_ctl.bump[IDX_PERFECT],
        is_term && (r_runs == RUNS_ONE) && r_last_match)
    `CIG_ASSERT_SAME(a_term_waits_for_slot, i_clk, i_rst_n, proc_fire && is_term,
        out_free)
    `CIG_ASSERT_SAME(a_runs_bounded, i_clk, i_rst_n, 1'b1,
        (r_runs == RUNS_NONE) || (r_runs == RUNS_ONE) || (r_runs == RUNS_MANY))

endmodule
